[sv/mtr_pkg.sv]
// ----------------------------------------------------------------------------
// mtr_pkg: shared types, constants and helpers of the multitone block
// sequencer states, tone selection, sine polynomial coefficients, rounding
// ----------------------------------------------------------------------------
package mtr_pkg;

  // parameter defaults
  localparam int PHASE_BITS_DEF      = 32;
  localparam int SINE_TABLE_BITS_DEF = 10;

  // shared multiplier operand and product widths
  localparam int OP_W   = 33;
  localparam int PROD_W = 2 * OP_W;

  // 1/(2*pi) in Q0.32
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

  // odd Taylor coefficients of sin(pi/2*x) in Q30
  localparam logic signed [31:0] SIN_K1 = 32'sd1686629713;
  localparam logic signed [31:0] SIN_K3 = -32'sd693598668;
  localparam logic signed [31:0] SIN_K5 = 32'sd85569306;
  localparam logic signed [31:0] SIN_K7 = -32'sd5026994;
  localparam logic signed [31:0] SIN_K9 = 32'sd172272;

  // configuration register indexes
  localparam logic [1:0] CFG_DECAY_RATE     = 2'd0;
  localparam logic [1:0] CFG_INPUT_GAIN     = 2'd1;
  localparam logic [1:0] CFG_TONE_AMPLITUDE = 2'd2;

  // configuration reset values
  localparam logic [15:0] DECAY_RATE_RST     = 16'd655;
  localparam logic [15:0] INPUT_GAIN_RST     = 16'd4096;
  localparam logic [14:0] TONE_AMPLITUDE_RST = 15'd4096;

  typedef enum logic [1:0] {
    TONE_1,
    TONE_2,
    TONE_3,
    TONE_10
  } tone_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_INC,
    ST_TONE,
    ST_X2,
    ST_HORNER,
    ST_SIN,
    ST_SIN_RND,
    ST_AMP,
    ST_GAIN,
    ST_DECAY,
    ST_TERM_RND,
    ST_DT_HI,
    ST_DT_LO,
    ST_STEP_RND,
    ST_UPDATE
  } mtr_state_e;

  // folded sine argument: quarter-wave position in Q30 and sign of the half-wave
  typedef struct packed {
    logic        neg;
    logic [30:0] mag;
  } tone_arg_t;

  // arithmetic shift right by s, rounding half away from zero
  function automatic logic signed [PROD_W-1:0] rnd_shr(input logic signed [PROD_W-1:0] v,
                                                       input int unsigned s);
    logic signed [PROD_W-1:0] half;
    logic signed [PROD_W-1:0] bias;
    half        = '0;
    half[s-1]   = 1'b1;
    bias        = half - $signed({{(PROD_W-1){1'b0}}, v[PROD_W-1]});
    rnd_shr     = (v + bias) >>> s;
  endfunction

  // horner coefficient added after each multiply step, highest order first
  function automatic logic signed [31:0] horner_k(input logic [1:0] idx);
    logic signed [31:0] k;
    case (idx)
      2'd0:    k = SIN_K7;
      2'd1:    k = SIN_K5;
      2'd2:    k = SIN_K3;
      default: k = SIN_K1;
    endcase
    horner_k = k;
  endfunction

endpackage

[sv/mtr_mul.sv]
// ----------------------------------------------------------------------------
// mtr_mul: shared signed multiplier
// one 33x33 signed multiply per cycle with a registered product
// ----------------------------------------------------------------------------
module mtr_mul import mtr_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [OP_W-1:0]   op_a_i,
  input  logic signed [OP_W-1:0]   op_b_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
  end

  assign prod_o = prod_q;

endmodule

[sv/mtr_tone.sv]
// ----------------------------------------------------------------------------
// mtr_tone: tone argument folding
// scales the phase by the tone multiple and folds it onto a quarter wave
// ----------------------------------------------------------------------------
module mtr_tone import mtr_pkg::*; #(
  parameter int PHASE_BITS      = PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic [PHASE_BITS-1:0] phase_i,
  input  tone_sel_e             sel_i,
  output tone_arg_t             arg_o
);

  localparam int QBITS = SINE_TABLE_BITS - 2;
  localparam int XSHIFT = 32 - SINE_TABLE_BITS;

  logic [PHASE_BITS-1:0]      mphase;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [1:0]                 quad;
  logic [QBITS-1:0]           frac;
  logic [QBITS:0]             pos;

  // multiple of the phase, wrapping modulo one turn
  always_comb begin
    case (sel_i)
      TONE_1:  mphase = phase_i;
      TONE_2:  mphase = phase_i << 1;
      TONE_3:  mphase = phase_i + (phase_i << 1);
      TONE_10: mphase = (phase_i << 3) + (phase_i << 1);
      default: mphase = phase_i;
    endcase
  end

  assign idx  = mphase[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign quad = idx[SINE_TABLE_BITS-1 -: 2];
  assign frac = idx[QBITS-1:0];
  // odd quadrants run backwards
  assign pos  = quad[0] ? ({1'b1, {QBITS{1'b0}}} - {1'b0, frac}) : {1'b0, frac};

  assign arg_o.neg = quad[1];
  assign arg_o.mag = {pos, {XSHIFT{1'b0}}};

endmodule

[sv/multitone_reference_model.sv]
// ----------------------------------------------------------------------------
// multitone_reference_model: multisine reference and first-order euler model
// one word at a time: the next input word is taken only in the idle state, once the
// previous word has finished its 30 passes through one multiplier
// the update step waits while the previous result word is still held
// reset: phase and model state cleared, registers to defaults, no clearing pass
// ----------------------------------------------------------------------------
module multitone_reference_model import mtr_pkg::*; #(
  parameter int PHASE_BITS      = PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] time_step
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [31:0] model_output, [47:32] reference_value
);

  // phase increment comes out of the multiplier in Q0.48 turns
  localparam int INC_SHIFT = 48 - PHASE_BITS;

  // sequencer
  mtr_state_e state_q, state_d;
  mtr_state_e ret_q, ret_d;       // where to go once the multiplier has a product
  tone_sel_e  tone_q, tone_d;
  logic [1:0] cnt_q, cnt_d;       // horner step

  // configuration
  logic [15:0] decay_q;
  logic [15:0] gain_q;
  logic [14:0] amp_q;

  // architectural state
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic signed [31:0]    x_q, x_d;

  // working registers
  logic [15:0]            dt_q, dt_d;
  logic signed [OP_W-1:0] op_a_q, op_a_d;
  logic signed [OP_W-1:0] op_b_q, op_b_d;
  logic [30:0]            mag_q, mag_d;
  logic                   neg_q, neg_d;
  logic [30:0]            x2_q, x2_d;
  logic signed [31:0]     p_q, p_d;
  logic signed [17:0]     sum_q, sum_d;
  logic signed [15:0]     r_q, r_d;
  logic signed [48:0]     term_q, term_d;
  logic signed [57:0]     acc_q, acc_d;

  // output register
  logic               m_valid_q, m_valid_d;
  logic signed [31:0] out_x_q, out_x_d;
  logic signed [15:0] out_r_q, out_r_d;

  // datapath
  logic signed [PROD_W-1:0] prod_q;
  logic [47:0]              inc_full;
  tone_arg_t                targ;
  logic signed [PROD_W-1:0] rv;
  logic signed [31:0]       p_next;
  logic [14:0]              sin_mag;
  logic signed [17:0]       svalue;
  logic signed [17:0]       sum_next;
  logic signed [15:0]       r_next;
  logic signed [34:0]       nx;

  mtr_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (op_a_q),
    .op_b_i (op_b_q),
    .prod_o (prod_q)
  );

  mtr_tone #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_tone (
    .phase_i (phase_q),
    .sel_i   (tone_q),
    .arg_o   (targ)
  );

  // dt/(2*pi) in turns, cut down to the accumulator's fraction bits
  assign inc_full = {2'b00, prod_q[45:0]} >> INC_SHIFT;

  // --------------------------------------------------------------------------
  // sequencer: every multiply is operands loaded, the ST_MUL state, then a
  // post step that consumes the product and usually loads the next operands
  // --------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    tone_d    = tone_q;
    cnt_d     = cnt_q;
    phase_d   = phase_q;
    x_d       = x_q;
    dt_d      = dt_q;
    op_a_d    = op_a_q;
    op_b_d    = op_b_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    x2_d      = x2_q;
    p_d       = p_q;
    sum_d     = sum_q;
    r_d       = r_q;
    term_d    = term_q;
    acc_d     = acc_q;
    out_x_d   = out_x_q;
    out_r_d   = out_r_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    rv        = '0;
    p_next    = '0;
    sin_mag   = '0;
    svalue    = '0;
    sum_next  = '0;
    r_next    = '0;
    nx        = '0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          // phase increment: dt * 1/(2*pi)
          dt_d    = s_axis_tdata;
          op_a_d  = {17'd0, s_axis_tdata};
          op_b_d  = {3'd0, INV_TWO_PI_Q32};
          ret_d   = ST_INC;
          state_d = ST_MUL;
        end
      end

      ST_MUL: begin
        state_d = ret_q;
      end

      ST_INC: begin
        phase_d = phase_q + inc_full[PHASE_BITS-1:0];
        tone_d  = TONE_1;
        sum_d   = '0;
        state_d = ST_TONE;
      end

      // fold the tone's argument and square it
      ST_TONE: begin
        mag_d   = targ.mag;
        neg_d   = targ.neg;
        op_a_d  = {2'b00, targ.mag};
        op_b_d  = {2'b00, targ.mag};
        ret_d   = ST_X2;
        state_d = ST_MUL;
      end

      // x^2 in Q30, horner starts from the ninth-order coefficient
      ST_X2: begin
        rv      = rnd_shr(prod_q, 30);
        x2_d    = rv[30:0];
        op_a_d  = {SIN_K9[31], SIN_K9};
        op_b_d  = {2'b00, rv[30:0]};
        cnt_d   = '0;
        ret_d   = ST_HORNER;
        state_d = ST_MUL;
      end

      // p = k + p*x^2, four times, then the final multiply by x
      ST_HORNER: begin
        rv      = rnd_shr(prod_q, 30);
        p_next  = horner_k(cnt_q) + rv[31:0];
        op_a_d  = {p_next[31], p_next};
        if (cnt_q == 2'd3) begin
          op_b_d = {2'b00, mag_q};
          ret_d  = ST_SIN;
        end else begin
          op_b_d = {2'b00, x2_q};
          cnt_d  = cnt_q + 2'd1;
          ret_d  = ST_HORNER;
        end
        state_d = ST_MUL;
      end

      ST_SIN: begin
        rv      = rnd_shr(prod_q, 30);
        p_d     = rv[31:0];
        state_d = ST_SIN_RND;
      end

      // Q30 to Q14, clamp to [0, 1.0], restore sign, accumulate the tone
      ST_SIN_RND: begin
        rv = rnd_shr({{(PROD_W-32){p_q[31]}}, p_q}, 16);
        if (rv[PROD_W-1]) begin
          sin_mag = '0;
        end else if (rv[PROD_W-2:14] != '0) begin
          sin_mag = {1'b1, 14'd0};
        end else begin
          sin_mag = {1'b0, rv[13:0]};
        end
        svalue   = neg_q ? -$signed({3'b000, sin_mag}) : $signed({3'b000, sin_mag});
        sum_next = sum_q + svalue;
        sum_d    = sum_next;
        if (tone_q == TONE_10) begin
          op_a_d  = {{(OP_W-18){sum_next[17]}}, sum_next};
          op_b_d  = {{(OP_W-15){1'b0}}, amp_q};
          ret_d   = ST_AMP;
          state_d = ST_MUL;
        end else begin
          tone_d  = tone_sel_e'(tone_q + 2'd1);
          state_d = ST_TONE;
        end
      end

      // r = A*sum to Q2.14, saturated; next b*r
      ST_AMP: begin
        rv = rnd_shr(prod_q, 14);
        if (rv > 66'sd32767) begin
          r_next = 16'sh7fff;
        end else if (rv < -66'sd32768) begin
          r_next = -16'sh8000;
        end else begin
          r_next = rv[15:0];
        end
        r_d     = r_next;
        op_a_d  = {17'd0, gain_q};
        op_b_d  = {{(OP_W-16){r_next[15]}}, r_next};
        ret_d   = ST_GAIN;
        state_d = ST_MUL;
      end

      // b*r lined up with a*x in Q.40; next a*x
      ST_GAIN: begin
        term_d  = {prod_q[34:0], 14'd0};
        op_a_d  = {17'd0, decay_q};
        op_b_d  = {x_q[31], x_q};
        ret_d   = ST_DECAY;
        state_d = ST_MUL;
      end

      ST_DECAY: begin
        term_d  = term_q - $signed(prod_q[48:0]);
        state_d = ST_TERM_RND;
      end

      // derivative to Q.32; dt*term in two halves, upper half first
      ST_TERM_RND: begin
        rv      = rnd_shr({{(PROD_W-49){term_q[48]}}, term_q}, 8);
        term_d  = rv[48:0];
        op_a_d  = {{(OP_W-25){rv[40]}}, rv[40:16]};
        op_b_d  = {17'd0, dt_q};
        ret_d   = ST_DT_HI;
        state_d = ST_MUL;
      end

      ST_DT_HI: begin
        acc_d   = prod_q[57:0];
        op_a_d  = {17'd0, term_q[15:0]};
        op_b_d  = {17'd0, dt_q};
        ret_d   = ST_DT_LO;
        state_d = ST_MUL;
      end

      ST_DT_LO: begin
        acc_d   = $signed({acc_q[41:0], 16'd0}) + $signed(prod_q[57:0]);
        state_d = ST_STEP_RND;
      end

      // euler step to Q8.24
      ST_STEP_RND: begin
        rv      = rnd_shr({{(PROD_W-58){acc_q[57]}}, acc_q}, 24);
        acc_d   = rv[57:0];
        state_d = ST_UPDATE;
      end

      // saturating state update, waits while the output word is still held
      ST_UPDATE: begin
        if (!m_valid_q || m_axis_tready) begin
          nx = $signed({{3{x_q[31]}}, x_q}) + $signed(acc_q[34:0]);
          if (nx > 35'sd2147483647) begin
            x_d = 32'sh7fffffff;
          end else if (nx < -35'sd2147483648) begin
            x_d = -32'sh80000000;
          end else begin
            x_d = nx[31:0];
          end
          out_x_d   = x_d;
          out_r_d   = r_q;
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ret_q     <= ST_IDLE;
      tone_q    <= TONE_1;
      cnt_q     <= '0;
      phase_q   <= '0;
      x_q       <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      tone_q    <= tone_d;
      cnt_q     <= cnt_d;
      phase_q   <= phase_d;
      x_q       <= x_d;
      m_valid_q <= m_valid_d;
    end
  end

  // configuration registers, writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= DECAY_RATE_RST;
      gain_q  <= INPUT_GAIN_RST;
      amp_q   <= TONE_AMPLITUDE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DECAY_RATE:     decay_q <= cfg_data_i;
        CFG_INPUT_GAIN:     gain_q  <= cfg_data_i;
        CFG_TONE_AMPLITUDE: amp_q   <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    dt_q    <= dt_d;
    op_a_q  <= op_a_d;
    op_b_q  <= op_b_d;
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    x2_q    <= x2_d;
    p_q     <= p_d;
    sum_q   <= sum_d;
    r_q     <= r_d;
    term_q  <= term_d;
    acc_q   <= acc_d;
    out_x_q <= out_x_d;
    out_r_q <= out_r_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {out_r_q, out_x_q};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // a taken word always starts with the phase increment multiply
  a_accept_starts_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_MUL && ret_q == ST_INC))
    else $error("accepted word did not start the phase increment");

  // a new result word only ever comes from the update step
  a_result_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_UPDATE))
    else $error("result word raised outside the update step");

  // the update step holds while the previous word is still waiting
  a_update_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && m_axis_tvalid && !m_axis_tready) |=> (state_q == ST_UPDATE))
    else $error("update step overran a held result word");

  // the tone sum starts from zero for the fundamental
  a_sum_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TONE && tone_q == TONE_1) |-> (sum_q == '0))
    else $error("tone sum not cleared before the fundamental");

endmodule

[tb/sv/multitone_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multitone_checker: result predictor and comparator for the multitone model
// tracks register writes, predicts one result word per accepted time step word
// and compares each result word field by field in arrival order
// ----------------------------------------------------------------------------
module multitone_checker import mtr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [15:0] s_tdata_i,   // [15:0] time_step
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [47:0] m_tdata_i,   // [31:0] model_output, [47:32] reference_value
  output int          mismatches_o,
  output int          outstanding_o,
  output int          checked_o
);

  localparam int PHASE_W = 32;
  localparam int TABLE_W = 10;
  localparam int MAX_PRINTED = 100;

  localparam longint INV_2PI_Q32 = 64'sd683565276;
  localparam longint SK1 = 64'sd1686629713;
  localparam longint SK3 = -64'sd693598668;
  localparam longint SK5 = 64'sd85569306;
  localparam longint SK7 = -64'sd5026994;
  localparam longint SK9 = 64'sd172272;

  typedef struct packed {
    logic signed [31:0] model_output;
    logic signed [15:0] reference_value;
  } model_word_t;

  logic [15:0]         decay_reg;
  logic [15:0]         gain_reg;
  logic [14:0]         amp_reg;
  logic [PHASE_W-1:0]  tone_phase;
  int                  model_x;

  model_word_t predicted_outputs[$];
  model_word_t want;
  int          mismatch_count = 0;
  int          outstanding    = 0;
  int          checked        = 0;

  assign mismatches_o  = mismatch_count;
  assign outstanding_o = outstanding;
  assign checked_o     = checked;

  task automatic report_mismatch(input string field, input longint got, input longint exp_val);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("[%0t] mismatch on %s at result %0d: got %0d, expected %0d",
               $realtime, field, checked, got, exp_val);
  endtask

  function automatic longint shift_round(input longint v, input int unsigned s);
    logic            neg;
    longint unsigned mag;
    neg = (v < 0);
    mag = neg ? -v : v;
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  // quarter-wave folded sine, odd polynomial in q30
  function automatic longint sine_lookup(input logic [TABLE_W-1:0] k);
    logic [1:0] quadrant;
    longint     pos;
    longint     x;
    longint     x2;
    longint     p;
    longint     s;
    quadrant = k[TABLE_W-1 -: 2];
    pos      = k[TABLE_W-3:0];
    if (quadrant[0]) pos = (64'sd1 <<< (TABLE_W - 2)) - pos;
    x  = pos <<< (32 - TABLE_W);
    x2 = shift_round(x * x, 30);
    p  = SK9;
    p  = SK7 + shift_round(p * x2, 30);
    p  = SK5 + shift_round(p * x2, 30);
    p  = SK3 + shift_round(p * x2, 30);
    p  = SK1 + shift_round(p * x2, 30);
    s  = shift_round(shift_round(p * x, 30), 16);
    if (s < 0) s = 0;
    if (s > 16384) s = 16384;
    return quadrant[1] ? -s : s;
  endfunction

  function automatic longint tone_value(input int unsigned mult);
    logic [PHASE_W-1:0] ph;
    ph = tone_phase * mult;
    return sine_lookup(ph[PHASE_W-1 -: TABLE_W]);
  endfunction

  // one tick: advance phase, form the multisine, euler step of the state
  function automatic model_word_t advance_model(input logic [15:0] dt);
    longint      inc;
    longint      sum;
    longint      r;
    longint      term;
    longint      delta;
    longint      nx;
    model_word_t w;
    inc        = (longint'(dt) * INV_2PI_Q32) >> (48 - PHASE_W);
    tone_phase = tone_phase + inc[PHASE_W-1:0];
    sum = tone_value(1) + tone_value(2) + tone_value(3) + tone_value(10);
    r   = shift_round(sum * longint'(amp_reg), 14);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    term  = longint'(gain_reg) * r * 16384 - longint'(decay_reg) * longint'(model_x);
    term  = shift_round(term, 8);
    delta = shift_round(term * longint'(dt), 24);
    nx    = longint'(model_x) + delta;
    if (nx > 64'sd2147483647) nx = 64'sd2147483647;
    if (nx < -64'sd2147483648) nx = -64'sd2147483648;
    model_x = int'(nx);
    w.model_output    = model_x;
    w.reference_value = r[15:0];
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_reg  = DECAY_RATE_RST;
      gain_reg   = INPUT_GAIN_RST;
      amp_reg    = TONE_AMPLITUDE_RST;
      tone_phase = '0;
      model_x    = 0;
      predicted_outputs.delete();
      outstanding = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DECAY_RATE:     decay_reg = cfg_data_i;
          CFG_INPUT_GAIN:     gain_reg  = cfg_data_i;
          CFG_TONE_AMPLITUDE: amp_reg   = cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        if (predicted_outputs.size() == 0) begin
          report_mismatch("result word with nothing expected", $signed(m_tdata_i[31:0]), 0);
        end else begin
          want = predicted_outputs.pop_front();
          if (m_tdata_i[31:0] !== want.model_output)
            report_mismatch("model_output", $signed(m_tdata_i[31:0]), want.model_output);
          if (m_tdata_i[47:32] !== want.reference_value)
            report_mismatch("reference_value", $signed(m_tdata_i[47:32]),
                            want.reference_value);
          checked++;
        end
      end
      if (s_tvalid_i && s_tready_i) predicted_outputs.push_back(advance_model(s_tdata_i));
      outstanding = predicted_outputs.size();
    end
  end

endmodule

[tb/sv/tb_multitone_reference_model.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multitone_reference_model: stream-level test of the multitone model
// directed time steps and register extremes, then random register settings
// and time steps under three idling regimes, checked by a predicting monitor
// ----------------------------------------------------------------------------
module tb_multitone_reference_model;
  import mtr_pkg::*;

  localparam int         CYCLE_LIMIT     = 1_000_000;
  localparam int         HOLD_OFF_CYCLES = 3000;
  localparam int         DRAIN_CYCLES    = 100;
  localparam int         ITEMS_PER_SET   = 95;
  localparam int         SETS_PER_REGIME = 5;
  localparam logic [1:0] CFG_SPARE       = 2'd3;  // index with no register behind it

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_index_i   = CFG_DECAY_RATE;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // [15:0] time_step
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;         // [31:0] model_output, [47:32] reference_value

  int mismatches;
  int outstanding;
  int checked;

  int send_idle_pct = 37;
  int recv_idle_pct = 85;
  bit hold_request  = 1'b0;
  int hold_left     = 0;
  int cycle_count   = 0;
  int words_sent    = 0;
  int settings_used = 1;

  multitone_reference_model dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  multitone_checker u_result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random back-pressure, or a long hold-off when asked for
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // offer one time step word, with random idle cycles ahead of it
  // called and returning at a falling edge
  task automatic send_word(input logic [15:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= dt;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    @(negedge clk_i);
  endtask

  // stop offering and wait for every predicted result word to come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // write all three registers on consecutive cycles
  task automatic write_regs(input logic [15:0] decay, input logic [15:0] gain,
                            input logic [15:0] amp);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_DECAY_RATE;
    cfg_data_i  <= decay;
    @(negedge clk_i);
    cfg_index_i <= CFG_INPUT_GAIN;
    cfg_data_i  <= gain;
    @(negedge clk_i);
    cfg_index_i <= CFG_TONE_AMPLITUDE;
    cfg_data_i  <= amp;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_used++;
  endtask

  // register value: extremes, the usual setting, near it, or anything
  function automatic logic [15:0] pick_reg(input logic [15:0] usual);
    case ($urandom_range(5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return usual;
      3:       return 16'($urandom_range(2 * usual));
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // time step: zero, full scale, short ticks, single bits or anything
  function automatic logic [15:0] pick_step();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(255));
      4:       return 16'h0001 << $urandom_range(15);
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  logic [15:0] default_steps[10] = '{16'd0, 16'd1, 16'hFFFF, 16'hFFFF, 16'h8000,
                                     16'h5555, 16'hAAAA, 16'd256, 16'd4096, 16'd0};

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset register values: zero steps, full-scale steps, single-bit steps, alternating bits
    foreach (default_steps[i]) send_word(default_steps[i]);

    // no decay, top gain, amplitude with every bit set: reference and state saturate
    drain();
    write_regs(16'h0000, 16'hFFFF, 16'hFFFF);
    repeat (4) send_word(16'hFFFF);
    repeat (4) send_word(pick_step());

    // full decay, zero gain and amplitude: state relaxes with a zero reference,
    // plus a write to the unused index which must leave everything alone
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_SPARE;
    cfg_data_i  <= 16'($urandom_range(16'hFFFF));
    @(negedge clk_i);
    write_regs(16'hFFFF, 16'h0000, 16'h0000);
    repeat (5) send_word(16'hFFFF);

    // random part, three idling regimes
    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 85;
        end
        1: begin
          send_idle_pct = 85;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int set = 0; set < SETS_PER_REGIME; set++) begin
        drain();
        write_regs(pick_reg(DECAY_RATE_RST), pick_reg(INPUT_GAIN_RST),
                   pick_reg({1'b0, TONE_AMPLITUDE_RST}));
        for (int n = 0; n < ITEMS_PER_SET; n++) begin
          // result side stalls for a long stretch while words keep coming
          if (regime == 1 && set == 0 && n == 10) hold_request = 1'b1;
          send_word(pick_step());
        end
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("run: %0d time step words over %0d register settings, %0d results compared",
             words_sent, settings_used, checked);
    $display("     incl. register extremes, saturation, long result stall, three idle mixes");
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
